// File: src/gkda_pkg.sv
// Shared types and constants for the Gaussian kernel density accumulator.
package gkda_pkg;

    // Operation codes carried in the request word
    typedef enum logic [1:0] {
        OP_LOAD_WEIGHT = 2'd0,
        OP_ADD_SAMPLE  = 2'd1,
        OP_READ_BIN    = 2'd2,
        OP_CLEAR       = 2'd3
    } op_t;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 4;
    localparam logic [CFG_INDEX_W-1:0] CFG_INVERSE_BIN_WIDTH = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KERNEL_HALF_WIDTH = 4'd1;

    // Reset values of the configuration registers
    localparam logic [31:0] INV_BIN_WIDTH_RESET = 32'h0001_0000;
    localparam logic [5:0]  HALF_WIDTH_RESET    = 6'd32;

    // Saturation limits
    localparam logic [31:0] BIN_MAX   = 32'hFFFF_FFFF;
    localparam logic [47:0] TOTAL_MAX = 48'hFFFF_FFFF_FFFF;

    // Request word
    typedef struct packed {
        op_t         operation;
        logic [5:0]  tap_index;
        logic [15:0] tap_weight;
        logic [31:0] sample_time;
        logic [9:0]  bin_select;
    } req_t;

    // Response word
    typedef struct packed {
        logic [9:0]  bin_index;
        logic [31:0] bin_value;
        logic [47:0] total_weight;
    } rsp_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_item;     // capture request word, start the multiply
        logic kernel_write;  // load one kernel weight from the request
        logic tap_issue;     // issue one tap read of the read-modify-write
        logic read_issue;    // read the selected bin
        logic out_load;      // load the response register
        logic sweep;         // clear one bin at the counter address
        logic clear_total;   // zero the weight total
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic [6:0] tap_count;  // taps per sample, twice the effective half width
        logic       rsp_full;   // response register holds an untaken word
    } dp_stat_t;

endpackage

// File: src/gkda_ctrl.sv
// Controller state machine: sequences loads, tap sweeps, reads and clearing.
module gkda_ctrl #(
    parameter int BIN_COUNT = 1024,
    localparam int BIN_AW = $clog2(BIN_COUNT),
    localparam int CNT_W = ((BIN_AW > 7) ? BIN_AW : 7) + 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  gkda_pkg::op_t       req_op,
    output logic                req_stall,
    input  gkda_pkg::dp_stat_t  stat,
    output gkda_pkg::dp_cmd_t   cmd,
    output logic [CNT_W-1:0]    cnt
);
    import gkda_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_TAP,
        S_DRAIN,
        S_READ,
        S_RESP
    } state_t;

    localparam logic [CNT_W-1:0] LAST_BIN = CNT_W'(BIN_COUNT - 1);

    state_t           state_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             accept;
    logic [CNT_W-1:0] last_tap;

    assign cnt      = cnt_reg;
    assign last_tap = CNT_W'(stat.tap_count) - CNT_W'(1);

    // Handshake and commands
    always_comb
    begin
        cmd       = '0;
        req_stall = 1'b1;
        accept    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                // a read needs the response register free
                req_stall = (req_op == OP_READ_BIN) && stat.rsp_full;
                accept    = req_valid && !req_stall;
                if (accept)
                begin
                    cmd.load_item    = 1'b1;
                    cmd.kernel_write = (req_op == OP_LOAD_WEIGHT);
                    cmd.clear_total  = (req_op == OP_CLEAR);
                end
            end
            S_TAP:   cmd.tap_issue  = 1'b1;
            S_READ:  cmd.read_issue = 1'b1;
            S_RESP:  cmd.out_load   = 1'b1;
            S_CLEAR: cmd.sweep      = 1'b1;
            S_DRAIN: ;
            default: ;
        endcase
    end

    // State and counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cnt_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        cnt_reg <= '0;
                        unique case (req_op)
                            OP_ADD_SAMPLE:
                                state_reg <= (stat.tap_count == 7'd0) ? S_IDLE : S_TAP;
                            OP_READ_BIN:    state_reg <= S_READ;
                            OP_CLEAR:       state_reg <= S_CLEAR;
                            OP_LOAD_WEIGHT: state_reg <= S_IDLE;
                            default:        state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_TAP:
                begin
                    if (cnt_reg == last_tap)
                        state_reg <= S_DRAIN;
                    else
                        cnt_reg <= cnt_reg + CNT_W'(1);
                end
                S_DRAIN: state_reg <= S_IDLE;
                S_READ:  state_reg <= S_RESP;
                S_RESP:  state_reg <= S_IDLE;
                S_CLEAR:
                begin
                    if (cnt_reg == LAST_BIN)
                        state_reg <= S_IDLE;
                    else
                        cnt_reg <= cnt_reg + CNT_W'(1);
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// File: src/gkda_datapath.sv
// Datapath: configuration, bin mapping multiply, kernel and bin memories, total.
module gkda_datapath #(
    parameter int BIN_COUNT   = 1024,
    parameter int KERNEL_TAPS = 64,
    localparam int BIN_AW = $clog2(BIN_COUNT),
    localparam int CNT_W = ((BIN_AW > 7) ? BIN_AW : 7) + 1
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic [gkda_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [31:0]                        cfg_data,
    input  gkda_pkg::req_t                     req,
    input  gkda_pkg::dp_cmd_t                  cmd,
    input  logic [CNT_W-1:0]                   cnt,
    output gkda_pkg::dp_stat_t                 stat,
    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output gkda_pkg::rsp_t                     rsp
);
    import gkda_pkg::*;

    localparam int KERN_AW   = $clog2(KERNEL_TAPS);
    localparam int HALF_TAPS = KERNEL_TAPS / 2;

    // Configuration registers
    logic [31:0] inv_bw_reg;
    logic [5:0]  half_w_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_bw_reg <= INV_BIN_WIDTH_RESET;
            half_w_reg <= HALF_WIDTH_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_INVERSE_BIN_WIDTH)
                inv_bw_reg <= cfg_data;
            else if (cfg_index == CFG_KERNEL_HALF_WIDTH)
                half_w_reg <= cfg_data[5:0];
        end
    end

    // Effective half width, clipped to the table
    logic [5:0] eff_h;
    assign eff_h = (32'(half_w_reg) > 32'(HALF_TAPS)) ? 6'(HALF_TAPS) : half_w_reg;

    // Captured request word and the time-by-reciprocal product
    req_t        item_reg;
    logic [63:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= req;
            prod_reg <= {32'h0, req.sample_time} * {32'h0, inv_bw_reg};
        end
    end

    // Kernel table with per-entry valid bits; an unwritten slot reads zero
    logic [15:0]            kern_mem [KERNEL_TAPS];
    logic [KERNEL_TAPS-1:0] kvalid_reg;
    logic [KERN_AW-1:0]     kern_wa;
    logic [KERN_AW-1:0]     slot_addr;
    logic                   kern_we;
    logic [15:0]            kern_rd_reg;
    logic                   kv_rd_reg;

    assign kern_wa   = KERN_AW'(req.tap_index);
    assign kern_we   = cmd.kernel_write && (32'(req.tap_index) < 32'(KERNEL_TAPS));
    assign slot_addr = cnt[KERN_AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            kvalid_reg <= '0;
        else if (kern_we)
            kvalid_reg[kern_wa] <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (kern_we)
            kern_mem[kern_wa] <= req.tap_weight;
        if (cmd.tap_issue)
        begin
            kern_rd_reg <= kern_mem[slot_addr];
            kv_rd_reg   <= kvalid_reg[slot_addr];
        end
    end

    // Tap stage 0: bin = centre + slot - h, with range check
    logic [33:0]       bin_w;
    logic              tap_in_range;
    logic [BIN_AW-1:0] tap_addr;

    assign bin_w        = {2'b00, prod_reg[63:32]} + 34'(cnt) - 34'(eff_h);
    assign tap_in_range = !bin_w[33] && (bin_w < 34'(BIN_COUNT));
    assign tap_addr     = bin_w[BIN_AW-1:0];

    // Tap stage 1 registers
    logic              s1_valid_reg;
    logic [BIN_AW-1:0] s1_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= cmd.tap_issue && tap_in_range;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tap_issue)
            s1_addr_reg <= tap_addr;
    end

    // Bin memory: one write and one registered read port
    logic [31:0]       bin_mem [BIN_COUNT];
    logic [31:0]       rd_data_reg;
    logic [BIN_AW-1:0] sel_addr;
    logic [BIN_AW-1:0] bin_ra;
    logic [BIN_AW-1:0] bin_wa;
    logic [31:0]       bin_wd;
    logic              bin_re;
    logic              bin_we;
    logic [15:0]       s1_weight;
    logic [32:0]       bin_sum;
    logic [31:0]       bin_sat;

    assign sel_addr  = BIN_AW'(item_reg.bin_select);
    assign bin_re    = cmd.tap_issue || cmd.read_issue;
    assign bin_ra    = cmd.tap_issue ? tap_addr : sel_addr;
    assign s1_weight = kv_rd_reg ? kern_rd_reg : 16'd0;
    assign bin_sum   = {1'b0, rd_data_reg} + 33'(s1_weight);
    assign bin_sat   = bin_sum[32] ? BIN_MAX : bin_sum[31:0];
    assign bin_we    = cmd.sweep || s1_valid_reg;
    assign bin_wa    = cmd.sweep ? cnt[BIN_AW-1:0] : s1_addr_reg;
    assign bin_wd    = cmd.sweep ? 32'd0 : bin_sat;

    always_ff @(posedge clk)
    begin
        if (bin_we)
            bin_mem[bin_wa] <= bin_wd;
        if (bin_re)
            rd_data_reg <= bin_mem[bin_ra];
    end

    // Running weight total, saturating
    logic [47:0] total_reg;
    logic [48:0] total_sum;
    logic [47:0] total_next;

    assign total_sum  = {1'b0, total_reg} + 49'(s1_weight);
    assign total_next = total_sum[48] ? TOTAL_MAX : total_sum[47:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            total_reg <= '0;
        else if (cmd.clear_total)
            total_reg <= '0;
        else if (s1_valid_reg)
            total_reg <= total_next;
    end

    // Response register
    logic sel_ok;
    logic rsp_valid_reg;
    rsp_t rsp_reg;

    assign sel_ok = 32'(item_reg.bin_select) < 32'(BIN_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (cmd.out_load)
            rsp_valid_reg <= 1'b1;
        else if (!rsp_stall)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            rsp_reg.bin_index    <= item_reg.bin_select;
            rsp_reg.bin_value    <= sel_ok ? rd_data_reg : 32'd0;
            rsp_reg.total_weight <= total_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Status back to the controller
    assign stat = '{tap_count: {eff_h, 1'b0}, rsp_full: rsp_valid_reg};

endmodule

// File: src/gaussian_kernel_density_accumulator.sv
// Top level of the Gaussian kernel density accumulator.
//
// Usage:
//   req channel (req_valid / req_stall / req): one request word per accept.
//   Operations: load a kernel weight, add a sample, read a bin, clear bins.
//   rsp channel (rsp_valid / rsp_stall / rsp): one word per bin read.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): register
//   writes, always ready; write only while the block is idle.
// Request handling:
//   load weight is written on accept; read fetches the bin into a register,
//   then loads the response register; add sample sweeps 2*h taps, one tap
//   per cycle through a pipelined read-modify-write on the bin memory's
//   read and write ports; clear zeroes the total, then one bin per cycle.
// Reset: a clearing pass over all BIN_COUNT bins (1024 by default) zeroes the
//   bin memory; req_stall stays high meanwhile, cfg writes are still taken.
// Stall: a waiting response is held; other requests are still accepted,
//   a further read waits until the response word has been taken.
module gaussian_kernel_density_accumulator #(
    parameter int BIN_COUNT   = 1024,
    parameter int KERNEL_TAPS = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_stall,
    input  gkda_pkg::req_t                   req,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output gkda_pkg::rsp_t                   rsp,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [gkda_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                      cfg_data
);
    import gkda_pkg::*;

    localparam int BIN_AW = $clog2(BIN_COUNT);
    localparam int CNT_W  = ((BIN_AW > 7) ? BIN_AW : 7) + 1;

    dp_cmd_t          cmd;
    dp_stat_t         stat;
    logic [CNT_W-1:0] cnt;

    assign cfg_ready = 1'b1;

    gkda_ctrl #(
        .BIN_COUNT (BIN_COUNT)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_op    (req.operation),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd),
        .cnt       (cnt)
    );

    gkda_datapath #(
        .BIN_COUNT   (BIN_COUNT),
        .KERNEL_TAPS (KERNEL_TAPS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .cmd       (cmd),
        .cnt       (cnt),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // No read is taken while a response word still waits
    a_no_read_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && req_valid && !req_stall) |-> (req.operation != OP_READ_BIN))
        else $error("read accepted while response register full");

    // The response register is never overwritten before it is taken
    a_no_rsp_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !rsp_valid)
        else $error("response overwritten");

    // No request word is accepted during a clearing pass
    a_stall_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sweep |-> req_stall)
        else $error("request accepted during clearing pass");

endmodule
